>>> rtl/pal_pkg.sv
// Shared types, sizes and element conversion functions for the positional array list.
// No dependencies; every other file of the block imports this package.
package pal_pkg;

  localparam int CAPACITY   = 64;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 7;
  localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int GROUP_SZ   = 8;
  localparam int NUM_GRP    = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_ERASE  = 2'd3
  } pal_op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } pal_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_REDUCE
  } pal_state_e;

  typedef logic [ELEM_W-1:0] pal_elem_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              en;
    pal_op_e           op;
    logic [IDX_W-1:0]  idx;
    pal_elem_t         value;
  } pal_cmd_t;

  // Sign-extends the 32-bit input word and keeps the element bits.
  function automatic pal_elem_t to_elem(input logic [WORD_W-1:0] v);
    logic [63:0] w;
    w = {{(64 - WORD_W){v[WORD_W-1]}}, v};
    return w[ELEM_W-1:0];
  endfunction

  // Sign-extends a stored element and keeps the low 32 bits.
  function automatic logic [WORD_W-1:0] from_elem(input pal_elem_t e);
    logic [63:0] w;
    w = 64'(signed'(e));
    return w[WORD_W-1:0];
  endfunction

endpackage

>>> rtl/positional_array_list.sv
// Top level of the positional array list: request decode, control, cell chain and read path.
// Depends on pal_pkg, pal_cell and pal_read_tree.
//
// This block keeps an ordered list of up to CAPACITY signed words addressed by 1-based
// positions. Each input beat is one request (read, write, insert before a position, or
// erase at a position) and produces exactly one output beat with the read data, a status
// (ok, bad position, list full) and the list length after the request. The entries live in
// a row of cells; an insert or erase moves every later entry by one place, each cell taking
// its neighbor's word. A request passes through the states S_IDLE, S_SHIFT and S_REDUCE: in
// the first it is decoded against the current length and accepted, in the second the cells
// act and the selected cell's word is caught in a first rank of group registers, and in the
// third the groups are merged into the output register, waiting there while that register
// holds a result the downstream side has not taken. The input side is ready again as soon
// as the result sits in the output register, so a new request is taken only after the
// previous result is loaded. The entry storage has no reset; the length does.
module positional_array_list
  import pal_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // Fields from bit 0 up: action[1:0], position[8:2], value[40:9], zero pad.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // Fields from bit 0 up: read_data[31:0], status[33:32], list_length[40:34], zero pad.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Request fields.
  logic [1:0]        in_action;
  logic [POS_W-1:0]  in_position;
  logic [WORD_W-1:0] in_value;

  assign in_action   = s_axis_tdata_i[1:0];
  assign in_position = s_axis_tdata_i[2 +: POS_W];
  assign in_value    = s_axis_tdata_i[2 + POS_W +: WORD_W];

  pal_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  pal_cmd_t         cmd_q, cmd_d;
  pal_status_e      status_q, status_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_rdata_q;
  pal_status_e       out_status_q;
  logic [LEN_W-1:0]  out_len_q;

  logic accept, shift_phase, load_out;

  // Decode of the request against the current length.
  logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext;
  logic             pos_ok_rw, pos_ok_ins, is_full;
  pal_op_e          op_in;

  assign pos_ext    = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_q);
  assign idx_ext    = pos_ext - CMP_W'(1);
  assign pos_ok_rw  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign is_full    = (cnt_ext == CMP_W'(CAPACITY));
  assign op_in      = pal_op_e'(in_action);

  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign shift_phase = (state_q == S_SHIFT);
  assign load_out    = (state_q == S_REDUCE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    status_d = STAT_OK;
    count_d  = count_q;
    case (op_in)
      OP_INSERT: begin
        if (!pos_ok_ins)   status_d = STAT_BAD_POS;
        else if (is_full)  status_d = STAT_FULL;
        else               count_d  = count_q + CNT_W'(1);
      end
      OP_ERASE: begin
        if (!pos_ok_rw) status_d = STAT_BAD_POS;
        else            count_d  = count_q - CNT_W'(1);
      end
      default: begin
        if (!pos_ok_rw) status_d = STAT_BAD_POS;
      end
    endcase
    cmd_d.en    = (status_d == STAT_OK);
    cmd_d.op    = op_in;
    cmd_d.idx   = idx_ext[IDX_W-1:0];
    cmd_d.value = to_elem(in_value);
    len_d       = LEN_W'(count_d);
  end

  // Control sequencer.
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        state_d = S_REDUCE;
      end
      S_REDUCE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out)             out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Decoded request; no reset needed, the cells only look at it in the shift cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_d;
      status_q <= status_d;
      len_q    <= len_d;
    end
  end

  // The cells see the command only during the shift cycle.
  pal_cmd_t cell_cmd;

  always_comb begin
    cell_cmd    = cmd_q;
    cell_cmd.en = cmd_q.en && shift_phase;
  end

  pal_elem_t cell_data [CAPACITY];
  pal_elem_t cell_rd   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pal_elem_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[i+1];
    end
    pal_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .cmd_i      (cell_cmd),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  pal_elem_t tree_rd;

  pal_read_tree u_read_tree (
    .clk_i     (clk_i),
    .load_i    (shift_phase),
    .cell_rd_i (cell_rd),
    .rd_o      (tree_rd)
  );

  // Output register; it holds the result while the next request is decoded.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rdata_q  <= from_elem(tree_rd);
      out_status_q <= status_q;
      out_len_q    <= len_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - WORD_W - 2 - LEN_W){1'b0}},
                            out_len_q, out_status_q, out_rdata_q};

endmodule

>>> rtl/pal_cell.sv
// One cell of the list chain: holds a single entry and takes its neighbors' data on shifts.
// Depends on pal_pkg.
module pal_cell
  import pal_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  pal_cmd_t         cmd_i,
  input  pal_elem_t        left_i,
  input  pal_elem_t        right_i,
  output pal_elem_t        data_o,
  output pal_elem_t        rd_o
);

  pal_elem_t data_q, data_d;
  logic      hit, above;

  assign hit   = (cell_idx_i == cmd_i.idx);
  assign above = (cell_idx_i > cmd_i.idx);

  always_comb begin
    data_d = data_q;
    if (cmd_i.en) begin
      case (cmd_i.op)
        OP_WRITE: begin
          if (hit) data_d = cmd_i.value;
        end
        OP_INSERT: begin
          if (hit)        data_d = cmd_i.value;
          else if (above) data_d = left_i;
        end
        OP_ERASE: begin
          if (hit || above) data_d = right_i;
        end
        default: begin
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.en && cmd_i.op == OP_READ && hit) ? data_q : '0;

endmodule

>>> rtl/pal_read_tree.sv
// Registered OR tree that collects the one selected cell's read data.
// Depends on pal_pkg.
module pal_read_tree
  import pal_pkg::*;
(
  input  logic      clk_i,
  input  logic      load_i,
  input  pal_elem_t cell_rd_i [CAPACITY],
  output pal_elem_t rd_o
);

  pal_elem_t grp_q [NUM_GRP];
  pal_elem_t grp_d [NUM_GRP];

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < CAPACITY) grp_d[g] = grp_d[g] | cell_rd_i[g * GROUP_SZ + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int g = 0; g < NUM_GRP; g++) grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    rd_o = '0;
    for (int g = 0; g < NUM_GRP; g++) rd_o = rd_o | grp_q[g];
  end

endmodule
